### hw/rtl/deq_pkg.sv
// Shared types and constants for the double-ended queue unit.
// Standalone; every other file in hw/rtl imports it.
package deq_pkg;

    localparam int DEQ_DEPTH = 16;
    localparam int DATA_W    = 32;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_REAR  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_REAR   = 3'd3,
        MODE_LIST       = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CMD_HOLD       = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PUSH_REAR  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_REAR   = 3'd4,
        CMD_ROTATE     = 3'd5
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                 cmd;
        logic signed [DATA_W-1:0]  value;
    } cell_ctl_t;

endpackage

### hw/rtl/deq_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on deq_pkg for the data width.
interface deq_req_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
endinterface

interface deq_rsp_if;
    import deq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic                     last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

### hw/rtl/deq_cell.sv
// One storage cell of the queue chain: an entry and its valid bit.
// Depends on deq_pkg for the command struct.
module deq_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  deq_pkg::cell_ctl_t               ctl,
    input  logic signed [deq_pkg::DATA_W-1:0] wrap_data,
    input  logic                             left_valid,
    input  logic signed [deq_pkg::DATA_W-1:0] left_data,
    input  logic                             right_valid,
    input  logic signed [deq_pkg::DATA_W-1:0] right_data,
    output logic                             valid,
    output logic signed [deq_pkg::DATA_W-1:0] data
);
    import deq_pkg::*;

    logic                     valid_reg;
    logic                     valid_next;
    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        unique case (ctl.cmd)
            CMD_PUSH_FRONT:
            begin
                valid_next = left_valid;
                data_next  = left_data;
            end
            CMD_PUSH_REAR:
            begin
                if (!valid_reg && left_valid)
                begin
                    valid_next = 1'b1;
                    data_next  = ctl.value;
                end
            end
            CMD_POP_FRONT:
            begin
                valid_next = right_valid;
                data_next  = right_data;
            end
            CMD_POP_REAR:
            begin
                if (valid_reg && !right_valid)
                    valid_next = 1'b0;
            end
            CMD_ROTATE:
            begin
                if (right_valid)
                    data_next = right_data;
                else if (valid_reg)
                    data_next = wrap_data;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

### hw/rtl/deq_chain.sv
// Row of queue cells, front at cell 0, with front and rear taps.
// Depends on deq_pkg and deq_cell.
module deq_chain #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  deq_pkg::cell_ctl_t               ctl,
    output logic [DEPTH-1:0]                 valid,
    output logic signed [deq_pkg::DATA_W-1:0] front,
    output logic signed [deq_pkg::DATA_W-1:0] rear
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic [DEPTH-1:0]         is_last;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic                     lv;
            logic signed [DATA_W-1:0] ld;
            logic                     rv;
            logic signed [DATA_W-1:0] rd;

            if (i == 0)
            begin : g_head
                assign lv = 1'b1;
                assign ld = ctl.value;
            end
            else
            begin : g_mid_l
                assign lv = valid[i-1];
                assign ld = cell_data[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign rv = 1'b0;
                assign rd = '0;
            end
            else
            begin : g_mid_r
                assign rv = valid[i+1];
                assign rd = cell_data[i+1];
            end

            deq_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .wrap_data   (cell_data[0]),
                .left_valid  (lv),
                .left_data   (ld),
                .right_valid (rv),
                .right_data  (rd),
                .valid       (valid[i]),
                .data        (cell_data[i])
            );
        end
    endgenerate

    assign is_last = valid & ~(valid >> 1);
    assign front   = cell_data[0];

    always_comb
    begin
        rear = '0;
        for (int k = 0; k < DEPTH; k++)
            rear = rear | (cell_data[k] & {DATA_W{is_last[k]}});
    end

endmodule

### hw/rtl/double_ended_queue_unit.sv
// Double-ended queue of signed 32-bit values held in a chain of DEPTH cells.
// Push front, push rear, pop front and pop rear each give one response; a full
// queue answers a push with overflow, an empty one a pop with underflow. A
// listing rotates the chain once per stored entry, one response per cycle while
// the response channel is free, front to rear with last on the final one; an
// empty queue answers a listing with a single response of the empty status.
// No request is taken during a listing. Modes 5 to 7 are dropped without a response.
// Depends on deq_pkg, deq_if, deq_chain.
module double_ended_queue_unit #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    deq_req_if.sink    req,
    deq_rsp_if.source  rsp
);
    import deq_pkg::*;

    localparam int CntW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [CntW-1:0]          occ_reg;
    logic [CntW-1:0]          occ_next;
    logic [CntW-1:0]          list_cnt_reg;
    logic [CntW-1:0]          list_cnt_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    status_t                  out_status_reg;
    status_t                  out_status_next;
    logic signed [DATA_W-1:0] out_data_reg;
    logic signed [DATA_W-1:0] out_data_next;
    logic                     out_last_reg;
    logic                     out_last_next;

    cell_ctl_t                ctl;
    logic [DEPTH-1:0]         cell_valid;
    logic signed [DATA_W-1:0] front;
    logic signed [DATA_W-1:0] rear;
    logic                     full;
    logic                     empty;
    logic                     out_free;
    logic                     accept;
    logic                     emit;

    deq_chain #(.DEPTH(DEPTH)) u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .valid (cell_valid),
        .front (front),
        .rear  (rear)
    );

    assign full     = cell_valid[DEPTH-1];
    assign empty    = !cell_valid[0];
    assign out_free = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept   = req.valid && req.ready;

    always_comb
    begin
        ctl.cmd         = CMD_HOLD;
        ctl.value       = req.value;
        state_next      = state_reg;
        occ_next        = occ_reg;
        list_cnt_next   = list_cnt_reg;
        emit            = 1'b0;
        out_status_next = ST_OK;
        out_data_next   = '0;
        out_last_next   = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode_t'(req.mode)) inside
                        MODE_PUSH_FRONT, MODE_PUSH_REAR:
                        begin
                            emit = 1'b1;
                            if (full)
                                out_status_next = ST_OVERFLOW;
                            else
                            begin
                                ctl.cmd  = (mode_t'(req.mode) == MODE_PUSH_FRONT) ?
                                           CMD_PUSH_FRONT : CMD_PUSH_REAR;
                                occ_next = occ_reg + 1'b1;
                            end
                        end
                        MODE_POP_FRONT, MODE_POP_REAR:
                        begin
                            emit = 1'b1;
                            if (empty)
                                out_status_next = ST_UNDERFLOW;
                            else if (mode_t'(req.mode) == MODE_POP_FRONT)
                            begin
                                ctl.cmd       = CMD_POP_FRONT;
                                out_data_next = front;
                                occ_next      = occ_reg - 1'b1;
                            end
                            else
                            begin
                                ctl.cmd       = CMD_POP_REAR;
                                out_data_next = rear;
                                occ_next      = occ_reg - 1'b1;
                            end
                        end
                        MODE_LIST:
                        begin
                            if (empty)
                            begin
                                emit            = 1'b1;
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next    = S_LIST;
                                list_cnt_next = occ_reg;
                            end
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    ctl.cmd       = CMD_ROTATE;
                    out_data_next = front;
                    out_last_next = (list_cnt_reg == CntW'(1));
                    list_cnt_next = list_cnt_reg - 1'b1;
                    if (list_cnt_reg == CntW'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (emit)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            list_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            list_cnt_reg  <= list_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_status_reg <= out_status_next;
            out_data_reg   <= out_data_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.last   = out_last_reg;

`ifndef SYNTH
    a_occ_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == CntW'($countones(cell_valid)))
        else $error("occupancy count disagrees with cell valid bits");

    a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid + 1'b1) & cell_valid) == '0)
        else $error("valid cells not packed toward the front");

    a_list_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> !req.ready)
        else $error("request taken during a listing");

    a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST && out_free && list_cnt_reg == CntW'(1))
        |=> (state_reg == S_IDLE && rsp.valid && rsp.last))
        else $error("listing did not end on its final entry");
`endif

endmodule
